/* rtl/core/uns_pkg.sv */
package uns_pkg;

  localparam int NAME_BYTES = 12;
  localparam int KEPT_DEPTH = NAME_BYTES + 1;

  localparam logic [7:0]  ASCII_END   = 8'h80;
  localparam logic [7:0]  LEAD2_MIN   = 8'hc2;
  localparam logic [7:0]  LEAD2_MAX   = 8'hdf;
  localparam logic [7:0]  LEAD3_MIN   = 8'he0;
  localparam logic [7:0]  LEAD3_MAX   = 8'hef;
  localparam logic [7:0]  LEAD4_MIN   = 8'hf0;
  localparam logic [7:0]  LEAD4_MAX   = 8'hf4;
  localparam logic [1:0]  CONT_TAG    = 2'b10;

  localparam logic [20:0] MIN_CODE2   = 21'h80;
  localparam logic [20:0] MIN_CODE3   = 21'h800;
  localparam logic [20:0] MIN_CODE4   = 21'h10000;
  localparam logic [20:0] MAX_CODE    = 21'h10ffff;
  localparam logic [20:0] SURR_LO     = 21'hd800;
  localparam logic [20:0] SURR_HI     = 21'hdfff;
  localparam logic [20:0] CODE_SPACE  = 21'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } uns_item_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  name_length;
    logic [63:0] name_low;
    logic [31:0] name_high;
  } uns_verdict_t;

  function automatic logic dropped_code(input logic [20:0] c);
    return (c < 21'h20) || (c inside {21'h7f, 21'h3c, 21'h3e, 21'h26, 21'h22, 21'h27});
  endfunction

  function automatic logic allowed_code(input logic [20:0] c);
    return (c inside {[21'h30:21'h39], [21'h41:21'h5a], [21'h61:21'h7a], 21'h5f,
                      [21'h3400:21'h4dbf], [21'h4e00:21'h9fff], [21'hf900:21'hfaff]});
  endfunction

endpackage

/* rtl/core/utf8_name_sanitizer_top.sv */
// Validates a user name streamed one byte per beat and closed by a beat with
// in_last set; that beat gives exactly one verdict beat with the trimmed name packed
// little-endian in out_name_low/out_name_high. It takes one byte every cycle unless
// in_stall is high: a beat is held in the input register, decoded and checked in a single
// stage, and a verdict is registered in the result register when its closing beat leaves
// the input register. in_stall rises only when a closing beat meets a full, stalled result
// register. cfg_ready is always high; write name_min_bytes only between names.
module utf8_name_sanitizer_top
  import uns_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [3:0]  out_name_length,
  output logic [63:0] out_name_low,
  output logic [31:0] out_name_high,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_name_min_bytes
);

  logic         s1_valid_r;
  uns_item_t    s1_item_r;
  logic         out_valid_r;
  uns_verdict_t out_r;
  logic [3:0]   min_r;
  logic         advance;
  logic         in_take;
  uns_verdict_t verdict;

  assign advance  = s1_valid_r && (!s1_item_r.last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  uns_name_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .item      (s1_item_r),
    .min_bytes (min_r),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.data_byte <= in_data_byte;
      s1_item_r.has_byte  <= in_has_byte;
      s1_item_r.last      <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_item_r.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_item_r.last) begin
      out_r <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      min_r <= cfg_name_min_bytes;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_r.accepted;
  assign out_name_length = out_r.name_length;
  assign out_name_low    = out_r.name_low;
  assign out_name_high   = out_r.name_high;

endmodule

/* rtl/core/uns_name_core.sv */
module uns_name_core
  import uns_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  uns_item_t    item,
  input  logic [3:0]   min_bytes,
  output uns_verdict_t verdict
);

  logic [1:0]  pend_r,  pend_nxt;
  logic [20:0] code_r,  code_nxt;
  logic [2:0]  seq_r,   seq_nxt;
  logic [3:0]  kept_r,  kept_nxt;
  logic [3:0]  store_r, store_nxt;
  logic [3:0]  trail_r, trail_nxt;
  logic        seen_r,  seen_nxt;
  logic        bad_r,   bad_nxt;
  logic        rej_r,   rej_nxt;
  logic [7:0]  buf_r   [NAME_BYTES];
  logic [7:0]  buf_nxt [NAME_BYTES];

  logic        take;
  logic        step_ok;
  logic [7:0]  b;
  logic [2:0]  seq_base;
  logic [4:0]  wr_idx;
  logic [20:0] c;
  logic        out_of_range;
  logic [4:0]  kept_sum;
  logic [3:0]  name_len;
  logic        ok;

  always_comb begin
    pend_nxt  = pend_r;
    code_nxt  = code_r;
    seq_nxt   = seq_r;
    kept_nxt  = kept_r;
    store_nxt = store_r;
    trail_nxt = trail_r;
    seen_nxt  = seen_r;
    bad_nxt   = bad_r;
    rej_nxt   = rej_r;
    for (int i = 0; i < NAME_BYTES; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    b            = item.data_byte;
    take         = go && item.has_byte && !rej_r;
    step_ok      = 1'b0;
    seq_base     = (pend_r == 2'd0) ? 3'd0 : seq_r;
    wr_idx       = {1'b0, store_r} + {2'b00, seq_base};
    c            = 21'd0;
    out_of_range = 1'b0;
    kept_sum     = 5'd0;

    if (take) begin
      if (pend_r == 2'd0) begin
        if (b < ASCII_END) begin
          code_nxt = {13'd0, b};
          pend_nxt = 2'd0;
          step_ok  = 1'b1;
        end else if (b inside {[LEAD2_MIN:LEAD2_MAX]}) begin
          code_nxt = {16'd0, b[4:0]};
          pend_nxt = 2'd1;
          step_ok  = 1'b1;
        end else if (b inside {[LEAD3_MIN:LEAD3_MAX]}) begin
          code_nxt = {17'd0, b[3:0]};
          pend_nxt = 2'd2;
          step_ok  = 1'b1;
        end else if (b inside {[LEAD4_MIN:LEAD4_MAX]}) begin
          code_nxt = {18'd0, b[2:0]};
          pend_nxt = 2'd3;
          step_ok  = 1'b1;
        end else begin
          rej_nxt = 1'b1;
        end
      end else if (b[7:6] != CONT_TAG) begin
        rej_nxt  = 1'b1;
        pend_nxt = 2'd0;
      end else begin
        code_nxt = {code_r[14:0], b[5:0]};
        pend_nxt = pend_r - 2'd1;
        step_ok  = 1'b1;
      end
    end

    if (step_ok) begin
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (wr_idx == 5'(i)) begin
          buf_nxt[i] = b;
        end
      end
      seq_nxt = seq_base + 3'd1;
      if (pend_nxt == 2'd0) begin
        c = code_nxt;
        out_of_range = ((seq_nxt == 3'd2) && (c < MIN_CODE2)) ||
                       ((seq_nxt == 3'd3) && (c < MIN_CODE3)) ||
                       ((seq_nxt == 3'd4) && (c < MIN_CODE4)) ||
                       (c > MAX_CODE) || ((c >= SURR_LO) && (c <= SURR_HI));
        kept_sum = {1'b0, kept_r} + {2'b00, seq_nxt};
        seq_nxt  = 3'd0;
        code_nxt = 21'd0;
        if (out_of_range) begin
          rej_nxt = 1'b1;
        end else if (!dropped_code(c)) begin
          if (kept_sum > 5'(KEPT_DEPTH)) begin
            rej_nxt = 1'b1;
          end else begin
            kept_nxt = kept_sum[3:0];
            if (c == CODE_SPACE) begin
              if (seen_r) begin
                store_nxt = store_r + 4'd1;
                trail_nxt = trail_r + 4'd1;
              end
            end else begin
              if (!allowed_code(c) || (seen_r && (trail_r != 4'd0))) begin
                bad_nxt = 1'b1;
              end
              seen_nxt  = 1'b1;
              trail_nxt = 4'd0;
              store_nxt = store_r + {1'b0, seq_base + 3'd1};
            end
          end
        end
      end
    end

    name_len = store_nxt - trail_nxt;
    ok = !rej_nxt && (pend_nxt == 2'd0) && !bad_nxt && (name_len >= min_bytes) &&
         (name_len <= 4'(NAME_BYTES));
    verdict.accepted    = ok;
    verdict.name_length = ok ? name_len : 4'd0;
    verdict.name_low    = '0;
    verdict.name_high   = '0;
    for (int i = 0; i < 8; i++) begin
      if (ok && (4'(i) < name_len)) begin
        verdict.name_low[8*i +: 8] = buf_nxt[i];
      end
    end
    for (int i = 8; i < NAME_BYTES; i++) begin
      if (ok && (4'(i) < name_len)) begin
        verdict.name_high[8*(i-8) +: 8] = buf_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && item.last)) begin
      pend_r  <= '0;
      code_r  <= '0;
      seq_r   <= '0;
      kept_r  <= '0;
      store_r <= '0;
      trail_r <= '0;
      seen_r  <= 1'b0;
      bad_r   <= 1'b0;
      rej_r   <= 1'b0;
    end else if (go) begin
      pend_r  <= pend_nxt;
      code_r  <= code_nxt;
      seq_r   <= seq_nxt;
      kept_r  <= kept_nxt;
      store_r <= store_nxt;
      trail_r <= trail_nxt;
      seen_r  <= seen_nxt;
      bad_r   <= bad_nxt;
      rej_r   <= rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < NAME_BYTES; i++) begin
        buf_r[i] <= buf_nxt[i];
      end
    end
  end

endmodule

/* rtl/core/uns_checker.sv */
module uns_checker
  import uns_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_accepted,
  input logic [3:0]  out_name_length,
  input logic [63:0] out_name_low,
  input logic [31:0] out_name_high
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_accepted) &&
    $stable(out_name_length) && $stable(out_name_low) && $stable(out_name_high))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
    (out_name_length == 4'd0) && (out_name_low == 64'd0) && (out_name_high == 32'd0))
    else $error("rejected name carries data");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_name_length <= 4'(NAME_BYTES))
    else $error("name length above maximum");

  a_short_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted && (out_name_length <= 4'd8) |-> out_name_high == 32'd0)
    else $error("bytes past name length not zero");

endmodule

bind utf8_name_sanitizer_top uns_checker u_uns_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_accepted    (out_accepted),
  .out_name_length (out_name_length),
  .out_name_low    (out_name_low),
  .out_name_high   (out_name_high)
);
